// ----- hw/rtl/deadlock_safety_checker_core_defines.svh -----
// assertion macros for the deadlock safety checker
// expects signals named clock and reset in the module that uses them

`ifndef DEADLOCK_SAFETY_CHECKER_CORE_DEFINES_SVH
`define DEADLOCK_SAFETY_CHECKER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DSC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define DSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/dsc_pkg.sv -----
// shared types and constants of the deadlock safety checker
// no dependencies

package dsc_pkg;

   // fixed field widths of the channels
   localparam int OP_W        = 2;
   localparam int INDEX_W     = 3;
   localparam int AMOUNT_IN_W = 8;
   localparam int PID_W       = 3;
   localparam int FCOUNT_W    = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;

   // widths of the controller/datapath link, sized for the largest build
   localparam int PROC_ID_W = 4;
   localparam int RES_ID_W  = 4;
   localparam int COUNT_W   = 5;

   // operations
   localparam logic [OP_W-1:0] OP_LOAD_MATRIX = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_AVAIL  = 2'd1;
   localparam logic [OP_W-1:0] OP_EVALUATE    = 2'd2;

   // result kinds
   localparam logic KIND_ORDER   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_PROCESSES = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_RESOURCES = 1'd1;

   localparam logic [CSR_DATA_W-1:0] CSR_COUNT_RESET = 4'd8;

   // controller to datapath
   typedef struct packed {
      logic                 load_matrix;
      logic                 load_avail;
      logic                 init_eval;
      logic                 rd_en;
      logic                 add_en;
      logic                 grant;
      logic                 emit_order;
      logic                 emit_verdict;
      logic                 verdict_safe;
      logic [PROC_ID_W-1:0] proc;
      logic [RES_ID_W-1:0]  res;
      logic [COUNT_W-1:0]   order_idx;
   } dsc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic               need_fits;
      logic               proc_done;
      logic               out_free;
      logic [COUNT_W-1:0] grant_count;
   } dsc_status_type;

endpackage

// ----- hw/rtl/dsc_ctrl.sv -----
// sequencer of the deadlock safety checker: config registers, state machine, counters
// depends on dsc_pkg

module dsc_ctrl import dsc_pkg::*; #(
   parameter int MAX_PROCESSES = 8,
   parameter int MAX_RESOURCES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_W-1:0]        req_operation,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  dsc_status_type         status,
   output dsc_cmd_type            cmd
);

   localparam int PCNT_W = $clog2(MAX_PROCESSES + 1);
   localparam int RCNT_W = $clog2(MAX_RESOURCES + 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_PROC    = 3'd1;
   localparam logic [2:0] ST_CHK_RD  = 3'd2;
   localparam logic [2:0] ST_CHK_EV  = 3'd3;
   localparam logic [2:0] ST_ADD_RD  = 3'd4;
   localparam logic [2:0] ST_ADD_EV  = 3'd5;
   localparam logic [2:0] ST_EMIT    = 3'd6;
   localparam logic [2:0] ST_VERDICT = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [CSR_DATA_W-1:0] np_cfg_ff, np_cfg_in;
   logic [CSR_DATA_W-1:0] nr_cfg_ff, nr_cfg_in;
   logic [PCNT_W-1:0]     p_ff, p_in;
   logic [PCNT_W-1:0]     k_ff, k_in;
   logic [RCNT_W-1:0]     r_ff, r_in;
   logic                  found_ff, found_in;
   logic [PCNT_W-1:0]     np_eff;
   logic [RCNT_W-1:0]     nr_eff;
   logic                  r_last;
   logic                  all_granted;
   logic                  accept;

   // register writes, no read-back
   always_comb begin
      np_cfg_in = np_cfg_ff;
      nr_cfg_in = nr_cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_NUM_PROCESSES: np_cfg_in = csr_wdata;
            CSR_NUM_RESOURCES: nr_cfg_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp counts into 1..max
   always_comb begin
      if (np_cfg_ff == '0) begin
         np_eff = PCNT_W'(1);
      end else if (np_cfg_ff > MAX_PROCESSES) begin
         np_eff = PCNT_W'(MAX_PROCESSES);
      end else begin
         np_eff = PCNT_W'(np_cfg_ff);
      end
      if (nr_cfg_ff == '0) begin
         nr_eff = RCNT_W'(1);
      end else if (nr_cfg_ff > MAX_RESOURCES) begin
         nr_eff = RCNT_W'(MAX_RESOURCES);
      end else begin
         nr_eff = RCNT_W'(nr_cfg_ff);
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign r_last      = (r_ff == nr_eff - RCNT_W'(1));
   assign all_granted = (status.grant_count == COUNT_W'(np_eff));

   // next state and commands
   always_comb begin
      state_in = state_ff;
      p_in     = p_ff;
      k_in     = k_ff;
      r_in     = r_ff;
      found_in = found_ff;

      cmd              = '0;
      cmd.proc         = PROC_ID_W'(p_ff);
      cmd.res          = RES_ID_W'(r_ff);
      cmd.order_idx    = COUNT_W'(k_ff);
      cmd.verdict_safe = all_granted;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  OP_LOAD_MATRIX: cmd.load_matrix = 1'b1;
                  OP_LOAD_AVAIL:  cmd.load_avail  = 1'b1;
                  OP_EVALUATE: begin
                     cmd.init_eval = 1'b1;
                     p_in          = '0;
                     found_in      = 1'b0;
                     state_in      = ST_PROC;
                  end
                  default: ;
               endcase
            end
         end
         // pick the next unfinished process, or close the pass
         ST_PROC: begin
            if (p_ff == np_eff) begin
               if (all_granted) begin
                  k_in     = '0;
                  state_in = ST_EMIT;
               end else if (!found_ff) begin
                  state_in = ST_VERDICT;
               end else begin
                  p_in     = '0;
                  found_in = 1'b0;
               end
            end else if (status.proc_done) begin
               p_in = p_ff + PCNT_W'(1);
            end else begin
               r_in     = '0;
               state_in = ST_CHK_RD;
            end
         end
         ST_CHK_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CHK_EV;
         end
         // need against work, one resource per visit
         ST_CHK_EV: begin
            if (!status.need_fits) begin
               p_in     = p_ff + PCNT_W'(1);
               state_in = ST_PROC;
            end else if (r_last) begin
               r_in     = '0;
               state_in = ST_ADD_RD;
            end else begin
               r_in     = r_ff + RCNT_W'(1);
               state_in = ST_CHK_RD;
            end
         end
         ST_ADD_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_ADD_EV;
         end
         // release the allocation into work
         ST_ADD_EV: begin
            cmd.add_en = 1'b1;
            if (r_last) begin
               cmd.grant = 1'b1;
               found_in  = 1'b1;
               p_in      = p_ff + PCNT_W'(1);
               state_in  = ST_PROC;
            end else begin
               r_in     = r_ff + RCNT_W'(1);
               state_in = ST_ADD_RD;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_order = 1'b1;
               if ((k_ff + PCNT_W'(1)) == np_eff) begin
                  state_in = ST_VERDICT;
               end else begin
                  k_in = k_ff + PCNT_W'(1);
               end
            end
         end
         ST_VERDICT: begin
            if (status.out_free) begin
               cmd.emit_verdict = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         np_cfg_ff <= CSR_COUNT_RESET;
         nr_cfg_ff <= CSR_COUNT_RESET;
         p_ff      <= '0;
         k_ff      <= '0;
         r_ff      <= '0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         np_cfg_ff <= np_cfg_in;
         nr_cfg_ff <= nr_cfg_in;
         p_ff      <= p_in;
         k_ff      <= k_in;
         r_ff      <= r_in;
         found_ff  <= found_in;
      end
   end

endmodule

// ----- hw/rtl/dsc_datapath.sv -----
// datapath of the deadlock safety checker: matrix memory, work vector, grant order, result register
// depends on dsc_pkg and deadlock_safety_checker_core_defines.svh

`include "deadlock_safety_checker_core_defines.svh"

module dsc_datapath import dsc_pkg::*; #(
   parameter int MAX_PROCESSES = 8,
   parameter int MAX_RESOURCES = 8,
   parameter int AMOUNT_WIDTH  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dsc_cmd_type            cmd,
   output dsc_status_type         status,
   input  logic [INDEX_W-1:0]     req_process_index,
   input  logic [INDEX_W-1:0]     req_resource_index,
   input  logic [AMOUNT_IN_W-1:0] req_allocated_amount,
   input  logic [AMOUNT_IN_W-1:0] req_maximum_amount,
   input  logic [AMOUNT_IN_W-1:0] req_available_amount,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_result_kind,
   output logic [PID_W-1:0]       rsp_process_id,
   output logic                   rsp_is_safe,
   output logic [FCOUNT_W-1:0]    rsp_finished_count,
   output logic                   rsp_last
);

   localparam int PIDX_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int RIDX_W  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int GC_W    = $clog2(MAX_PROCESSES + 1);
   localparam int DEPTH   = MAX_PROCESSES * MAX_RESOURCES;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int AW      = AMOUNT_WIDTH;
   localparam int WORK_W  = AW + 4;
   localparam int NEED_W  = AW + 1;
   localparam int ENTRY_W = NEED_W + AW;
   localparam logic [WORK_W-1:0] WORK_LIMIT = '1;

   // matrix memory holds {need, allocation} per process and resource
   logic [ENTRY_W-1:0]       matrix_mem [DEPTH];
   logic [ENTRY_W-1:0]       rd_data_ff;
   logic [AW-1:0]            avail_ff [MAX_RESOURCES];
   logic [WORK_W-1:0]        work_ff [MAX_RESOURCES];
   logic [PID_W-1:0]         order_ff [MAX_PROCESSES];
   logic [MAX_PROCESSES-1:0] finished_ff, finished_in;
   logic [GC_W-1:0]          gc_ff, gc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_kind_ff;
   logic [PID_W-1:0]         rsp_pid_ff;
   logic                     rsp_safe_ff;
   logic [FCOUNT_W-1:0]      rsp_count_ff;
   logic                     rsp_last_ff;

   logic                     ld_matrix_ok;
   logic                     ld_avail_ok;
   logic [ADDR_W-1:0]        ld_addr;
   logic [ADDR_W-1:0]        rd_addr;
   logic [AW-1:0]            alloc_in;
   logic [AW-1:0]            max_in;
   logic [NEED_W-1:0]        need_in;
   logic signed [NEED_W-1:0] rd_need;
   logic [AW-1:0]            rd_alloc;
   logic [RIDX_W-1:0]        res_idx;
   logic [PIDX_W-1:0]        proc_idx;
   logic [WORK_W-1:0]        work_sel;
   logic signed [WORK_W:0]   need_ext;
   logic signed [WORK_W:0]   work_ext;
   logic [WORK_W:0]          work_sum;
   logic [WORK_W-1:0]        work_sat;
   logic                     out_free;
   logic                     emit_any;
   logic                     verdict_shown;

   // load decode, out-of-range indexes are dropped
   assign ld_matrix_ok = cmd.load_matrix && (req_process_index < MAX_PROCESSES)
                         && (req_resource_index < MAX_RESOURCES);
   assign ld_avail_ok  = cmd.load_avail && (req_resource_index < MAX_RESOURCES);
   assign ld_addr  = ADDR_W'(req_process_index * MAX_RESOURCES + req_resource_index);
   assign rd_addr  = ADDR_W'(cmd.proc * MAX_RESOURCES + cmd.res);
   assign alloc_in = AW'(req_allocated_amount);
   assign max_in   = AW'(req_maximum_amount);
   assign need_in  = {1'b0, max_in} - {1'b0, alloc_in};

   // matrix memory, one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (ld_matrix_ok) begin
         matrix_mem[ld_addr] <= {need_in, alloc_in};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= matrix_mem[rd_addr];
      end
   end

   // need compare and saturating release
   assign rd_need  = $signed(rd_data_ff[ENTRY_W-1 -: NEED_W]);
   assign rd_alloc = rd_data_ff[AW-1:0];
   assign res_idx  = RIDX_W'(cmd.res);
   assign proc_idx = PIDX_W'(cmd.proc);
   assign work_sel = work_ff[res_idx];
   assign need_ext = (WORK_W + 1)'(rd_need);
   assign work_ext = $signed({1'b0, work_sel});
   assign work_sum = {1'b0, work_sel} + (WORK_W + 1)'(rd_alloc);
   assign work_sat = work_sum[WORK_W] ? WORK_LIMIT : work_sum[WORK_W-1:0];

   // available vector and work vector
   always_ff @(posedge clock) begin
      if (ld_avail_ok) begin
         avail_ff[RIDX_W'(req_resource_index)] <= AW'(req_available_amount);
      end
      if (cmd.init_eval) begin
         for (int i = 0; i < MAX_RESOURCES; i++) begin
            work_ff[i] <= WORK_W'(avail_ff[i]);
         end
      end else if (cmd.add_en) begin
         work_ff[res_idx] <= work_sat;
      end
   end

   // grant order entries
   always_ff @(posedge clock) begin
      if (cmd.grant) begin
         order_ff[PIDX_W'(gc_ff)] <= PID_W'(cmd.proc);
      end
   end

   // finished marks and grant count
   always_comb begin
      finished_in = finished_ff;
      gc_in       = gc_ff;
      if (cmd.init_eval) begin
         finished_in = '0;
         gc_in       = '0;
      end else if (cmd.grant) begin
         finished_in[proc_idx] = 1'b1;
         gc_in                 = gc_ff + GC_W'(1);
      end
   end

   // result register frees when the transaction is taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_order || cmd.emit_verdict) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         finished_ff  <= '0;
         gc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         finished_ff  <= finished_in;
         gc_ff        <= gc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.emit_order) begin
         rsp_kind_ff  <= KIND_ORDER;
         rsp_pid_ff   <= order_ff[PIDX_W'(cmd.order_idx)];
         rsp_safe_ff  <= 1'b0;
         rsp_count_ff <= '0;
         rsp_last_ff  <= 1'b0;
      end else if (cmd.emit_verdict) begin
         rsp_kind_ff  <= KIND_VERDICT;
         rsp_pid_ff   <= '0;
         rsp_safe_ff  <= cmd.verdict_safe;
         rsp_count_ff <= FCOUNT_W'(gc_ff);
         rsp_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_process_id     = rsp_pid_ff;
   assign rsp_is_safe        = rsp_safe_ff;
   assign rsp_finished_count = rsp_count_ff;
   assign rsp_last           = rsp_last_ff;

   assign status.need_fits   = (need_ext <= work_ext);
   assign status.proc_done   = finished_ff[proc_idx];
   assign status.out_free    = out_free;
   assign status.grant_count = COUNT_W'(gc_ff);

   // terms for the checks below
   assign emit_any      = cmd.emit_order || cmd.emit_verdict;
   assign verdict_shown = rsp_valid_ff && rsp_last_ff && (rsp_kind_ff == KIND_VERDICT);

   // a result is only written into a free register
   `DSC_ASSERT_IMPLY(a_emit_free, emit_any, out_free, "emit into busy result register")
   // a process is granted at most once per evaluation
   `DSC_ASSERT_IMPLY(a_grant_once, cmd.grant, !finished_ff[proc_idx], "process granted twice")
   // a verdict shows up as the closing result
   `DSC_ASSERT_NEXT(a_verdict_out, cmd.emit_verdict, verdict_shown, "verdict not presented")

endmodule

// ----- hw/rtl/deadlock_safety_checker_core.sv -----
// top level of the deadlock safety checker (banker's safety check)
// depends on dsc_pkg, dsc_ctrl and dsc_datapath
//
//   channel   direction  handshake         payload
//   req_      in         req_valid/stall   operation, indexes, amounts
//   rsp_      out        rsp_valid/stall   kind, process id, verdict, count, last
//   csr_      in         csr_write_en      csr_index, csr_wdata (counts)
//
// a load is taken in idle and does not raise req_stall; an evaluation holds req_stall high until its verdict is out
// evaluation: a start state, then per pass a closing visit and per process a visit,
//   plus a read and an evaluate state per resource checked and per resource released
//   on a grant, all on the one matrix read port
// results follow at one per cycle while rsp_stall is low: np order entries and a verdict, or a verdict alone
// reset is synchronous; counts return to 8, stored amounts are undefined until loaded
// rsp_stall holds the result register and the sequencer waits on it

module deadlock_safety_checker_core import dsc_pkg::*; #(
   parameter int MAX_PROCESSES = 8,
   parameter int MAX_RESOURCES = 8,
   parameter int AMOUNT_WIDTH  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [INDEX_W-1:0]     req_process_index,
   input  logic [INDEX_W-1:0]     req_resource_index,
   input  logic [AMOUNT_IN_W-1:0] req_allocated_amount,
   input  logic [AMOUNT_IN_W-1:0] req_maximum_amount,
   input  logic [AMOUNT_IN_W-1:0] req_available_amount,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_result_kind,
   output logic [PID_W-1:0]       rsp_process_id,
   output logic                   rsp_is_safe,
   output logic [FCOUNT_W-1:0]    rsp_finished_count,
   output logic                   rsp_last,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   dsc_cmd_type    cmd;
   dsc_status_type status;

   // sequencer
   dsc_ctrl #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .MAX_RESOURCES (MAX_RESOURCES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .status        (status),
      .cmd           (cmd)
   );

   // storage, arithmetic and result register
   dsc_datapath #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .MAX_RESOURCES (MAX_RESOURCES),
      .AMOUNT_WIDTH  (AMOUNT_WIDTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_process_index    (req_process_index),
      .req_resource_index   (req_resource_index),
      .req_allocated_amount (req_allocated_amount),
      .req_maximum_amount   (req_maximum_amount),
      .req_available_amount (req_available_amount),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_process_id       (rsp_process_id),
      .rsp_is_safe          (rsp_is_safe),
      .rsp_finished_count   (rsp_finished_count),
      .rsp_last             (rsp_last)
   );

endmodule
